@@ sv/mf3_pkg.sv @@
// Package for the 3x3 median filter with averaged borders.
// Holds sizes, request and register codes, and the pipeline payload types.
// No dependencies.
package mf3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = 10;
    localparam int ROW_BITS    = 12;
    localparam int WID_BITS    = 11;
    localparam int RES_BITS    = SAMPLE_BITS + 1;
    localparam int OUT_BYTES   = (RES_BITS + ROW_BITS + COL_BITS + 7) / 8;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [8:0][SAMPLE_BITS-1:0] t_win;
    typedef logic [8:0][RES_BITS-1:0]    t_vals;

    // output position travelling with each result
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } t_meta;

    // window-update control for one item
    typedef struct packed {
        logic                   act;
        logic                   emit;
        logic                   is_sample;
        logic                   pre_zero;
        logic                   col_first;
        logic                   col_after;
        logic                   ge1;
        logic                   ge2;
        logic [COL_BITS-1:0]    addr;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   row0_skip;
        logic                   row2_skip;
        logic                   col0_skip;
        logic                   col2_skip;
        t_meta                  meta;
    } t_s1;

endpackage

@@ sv/median_filter_3x3_edge_average.sv @@
// An accepted transaction passes r1, r2, r3, r4, r5 and r_ov before its result
// reaches the master side. Throughput: one transaction per cycle unless m_tready stalls;
// a full frame needs width*height samples plus width+1 drain transactions, one result each.
// Reset: i_rst_n synchronous, active low; clears counters, window, valid bits and
// size registers (1024 x 1024). Line stores are not cleared: an entry is read only after
// it has been written in the current frame.
// Depends on mf3_pkg.
module median_filter_3x3_edge_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [0:0]  s_tuser,   // [0] req_type
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] filtered_doubled, [28:17] out_row, [38:29] out_col
    output logic        m_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int SB = mf3_pkg::SAMPLE_BITS;
    localparam int RB = mf3_pkg::RES_BITS;
    localparam int CB = mf3_pkg::COL_BITS;
    localparam int HB = mf3_pkg::ROW_BITS;
    localparam int WB = mf3_pkg::WID_BITS;

    // configuration and position state
    logic [WB-1:0] r_fw;
    logic [HB-1:0] r_fh;
    logic [HB-1:0] r_in_row, n_in_row;
    logic [CB-1:0] r_in_col, n_in_col;
    logic [HB-1:0] r_out_row, n_out_row;
    logic [CB-1:0] r_out_col, n_out_col;

    // line stores
    logic [SB-1:0] mem_upper [mf3_pkg::MAX_WIDTH];
    logic [SB-1:0] mem_lower [mf3_pkg::MAX_WIDTH];
    logic [SB-1:0] r_rd_up, r_rd_lo;

    // pipeline registers
    mf3_pkg::t_s1   r1, n1;
    mf3_pkg::t_win  r_win, n_win;
    logic           r2_v, r3_v, r4_v, r5_v, r_ov;
    mf3_pkg::t_vals r2_val, r3_val, r4_val;
    logic [3:0]     r2_k1, r2_k2, r3_k1, r3_k2, r4_k1, r4_k2;
    mf3_pkg::t_meta r2_meta, r3_meta, r4_meta, r5_meta, r_o_meta;
    logic [8:0][8:0] r3_beat;
    logic [8:0][3:0] r4_rank;
    logic [RB-1:0]  r5_a, r5_b;
    logic [RB-1:0]  r_o_res;

    logic          en, s_acc, cfg_acc, is_drain, ir_ge_h, s0_act, s0_emit, s0_last, wrap;
    logic [WB-1:0] w_eff;
    logic [CB-1:0] wm1;
    logic [HB-1:0] h_eff, hm1;
    logic [CB-1:0] rd_addr;
    logic [WB-1:0] in_col_inc, out_col_inc;

    assign en          = !r_ov || m_tready;
    assign s_tready    = en;
    assign s_acc       = s_tvalid && en;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;

    // clamp frame sizes
    always_comb begin
        if (r_fw < WB'(2)) w_eff = WB'(2);
        else if (r_fw > WB'(mf3_pkg::MAX_WIDTH)) w_eff = WB'(mf3_pkg::MAX_WIDTH);
        else w_eff = r_fw;
        wm1   = CB'(w_eff - WB'(1));
        h_eff = (r_fh < HB'(2)) ? HB'(2) : r_fh;
        hm1   = h_eff - HB'(1);
    end

    function automatic mf3_pkg::t_win shift_col(mf3_pkg::t_win w, logic [SB-1:0] t,
                                                logic [SB-1:0] m, logic [SB-1:0] b);
        mf3_pkg::t_win o;
        o    = w;
        o[0] = w[1]; o[1] = w[2]; o[2] = t;
        o[3] = w[4]; o[4] = w[5]; o[5] = m;
        o[6] = w[7]; o[7] = w[8]; o[8] = b;
        return o;
    endfunction

    // decode the transaction against the position counters
    always_comb begin
        is_drain    = (s_tuser[0] == mf3_pkg::REQ_DRAIN);
        ir_ge_h     = (r_in_row >= h_eff);
        wrap        = (r_out_col >= wm1);
        in_col_inc  = {1'b0, r_in_col} + WB'(1);
        out_col_inc = {1'b0, r_out_col} + WB'(1);
        s0_last     = (r_out_row == hm1) && (r_out_col == wm1);
        n1          = '0;
        n1.sample   = s_tdata;
        n1.is_sample = !is_drain;
        n1.row0_skip = (r_out_row == '0);
        n1.row2_skip = (r_out_row >= hm1);
        n1.col0_skip = (r_out_col == '0);
        n1.col2_skip = wrap;
        n1.meta.row  = r_out_row;
        n1.meta.col  = r_out_col;
        n1.meta.last = s0_last;
        if (!is_drain) begin
            s0_act       = !ir_ge_h && ({1'b0, r_in_col} < w_eff);
            n1.addr      = r_in_col;
            n1.ge1       = (r_in_row >= HB'(1));
            n1.ge2       = (r_in_row >= HB'(2));
            n1.pre_zero  = (r_in_col == '0) && n1.ge2;
            n1.col_first = (r_in_col != '0);
            n1.col_after = (r_in_col == '0);
            s0_emit      = (r_in_col == '0) ? n1.ge2 : n1.ge1;
        end else begin
            s0_act       = ir_ge_h;
            n1.ge1       = 1'b1;
            n1.ge2       = 1'b1;
            n1.pre_zero  = wrap;
            n1.col_first = !wrap;
            n1.col_after = wrap && (({1'b0, r_out_row} + (HB+1)'(2)) == {1'b0, h_eff});
            n1.addr      = wrap ? '0 : CB'(out_col_inc);
            s0_emit      = 1'b1;
        end
        n1.act  = s_acc && s0_act;
        n1.emit = s0_emit;
        rd_addr = n1.addr;

        // advance positions
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (n1.act) begin
            if (!is_drain) begin
                if (in_col_inc >= w_eff) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + HB'(1);
                end else begin
                    n_in_col = CB'(in_col_inc);
                end
            end
            if (s0_emit) begin
                if (s0_last) begin
                    n_in_row = '0; n_in_col = '0; n_out_row = '0; n_out_col = '0;
                end else if (out_col_inc >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + HB'(1);
                end else begin
                    n_out_col = CB'(out_col_inc);
                end
            end
        end
        if (cfg_acc) begin
            n_in_row = '0; n_in_col = '0; n_out_row = '0; n_out_col = '0;
        end
    end

    // window update and snapshot
    mf3_pkg::t_win  w1, snap;
    logic [SB-1:0]  c_top, c_mid, c_bot;
    mf3_pkg::t_vals n2_val;
    logic [3:0]     n2_k1, n2_k2;
    logic           row_skip, col_skip;

    always_comb begin
        c_top = r1.ge2 ? r_rd_up : '0;
        c_mid = r1.ge1 ? r_rd_lo : '0;
        c_bot = r1.is_sample ? r1.sample : '0;
        w1    = r1.pre_zero ? shift_col(r_win, '0, '0, '0) : r_win;
        snap  = r1.col_first ? shift_col(w1, c_top, c_mid, c_bot) : w1;
        n_win = r1.col_after ? shift_col(snap, c_top, c_mid, c_bot) : snap;
        for (int k = 0; k < 9; k++) begin
            if ((k < 3 && r1.row0_skip) || (k > 5 && r1.row2_skip) ||
                (k % 3 == 0 && r1.col0_skip) || (k % 3 == 2 && r1.col2_skip)) begin
                n2_val[k] = RB'(1) << (SB - 1);
            end else begin
                n2_val[k] = {snap[k][SB-1], snap[k]};
            end
        end
        row_skip = r1.row0_skip || r1.row2_skip;
        col_skip = r1.col0_skip || r1.col2_skip;
        if (!row_skip && !col_skip) begin
            n2_k1 = 4'd4; n2_k2 = 4'd4;
        end else if (row_skip && col_skip) begin
            n2_k1 = 4'd1; n2_k2 = 4'd2;
        end else begin
            n2_k1 = 4'd2; n2_k2 = 4'd3;
        end
    end

    // pairwise order, rank, select; the sum is formed in the payload stages
    logic [8:0][8:0] n3_beat;
    logic [8:0][3:0] n4_rank;
    logic [RB-1:0]   n5_a, n5_b;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            for (int j = 0; j < 9; j++) begin
                n3_beat[i][j] = (i != j) &&
                    (($signed(r2_val[j]) < $signed(r2_val[i])) ||
                     ((r2_val[j] == r2_val[i]) && (j < i)));
            end
            n4_rank[i] = 4'($countones(r3_beat[i]));
        end
        n5_a = '0;
        n5_b = '0;
        for (int i = 0; i < 9; i++) begin
            if (r4_rank[i] == r4_k1) n5_a = n5_a | r4_val[i];
            if (r4_rank[i] == r4_k2) n5_b = n5_b | r4_val[i];
        end
    end

    // line stores: registered read, write as the item leaves the window stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_up <= mem_upper[rd_addr];
            r_rd_lo <= mem_lower[rd_addr];
            if (r1.act && r1.is_sample) begin
                mem_lower[r1.addr] <= r1.sample;
                if (r1.ge1) mem_upper[r1.addr] <= r_rd_lo;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_val  <= n2_val;  r2_k1 <= n2_k1;  r2_k2 <= n2_k2;  r2_meta <= r1.meta;
            r3_beat <= n3_beat; r3_val <= r2_val; r3_k1 <= r2_k1; r3_k2 <= r2_k2;
            r3_meta <= r2_meta;
            r4_rank <= n4_rank; r4_val <= r3_val; r4_k1 <= r3_k1; r4_k2 <= r3_k2;
            r4_meta <= r3_meta;
            r5_a    <= n5_a;    r5_b <= n5_b;     r5_meta <= r4_meta;
            r_o_res <= r5_a + r5_b;
            r_o_meta <= r5_meta;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= WB'(1024);
            r_fh      <= HB'(1024);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r1        <= '0;
            r_win     <= '0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    mf3_pkg::REG_FRAME_WIDTH:  r_fw <= i_cfg_data[WB-1:0];
                    mf3_pkg::REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) begin
                r1   <= n1;
                if (r1.act) r_win <= n_win;
                r2_v <= r1.act && r1.emit;
                r3_v <= r2_v;
                r4_v <= r3_v;
                r5_v <= r4_v;
                r_ov <= r5_v;
            end
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {1'b0, r_o_meta.col, r_o_meta.row, r_o_res};
    assign m_tlast  = r_o_meta.last;

`ifndef SYNTH
    // the write of one item never meets a read of the next at the same entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(en && r1.act && r1.is_sample && n1.act && (rd_addr == r1.addr)))
        else $error("line store read/write clash");

    // the frame's last result restarts every position counter
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n1.act && n1.emit && s0_last) |=>
        (r_in_row == '0 && r_in_col == '0 && r_out_row == '0 && r_out_col == '0))
        else $error("positions not restarted after frame end");

    // a result marked last sits at the bottom-right corner
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_meta.last) |-> (r_o_meta.row == hm1 && r_o_meta.col == wm1))
        else $error("frame end flag at wrong position");
`endif

endmodule
